// ===== sv/hpq_pkg.sv =====
// Shared types and codes for the binary heap priority queue.
package hpq_pkg;

  localparam int IdW    = 16;
  localparam int ValW   = 32;
  localparam int StatW  = 2;
  localparam int HeldW  = 11;

  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_POP    = 1'b1;

  localparam logic [StatW-1:0] STAT_OK    = 2'd0;
  localparam logic [StatW-1:0] STAT_FULL  = 2'd1;
  localparam logic [StatW-1:0] STAT_EMPTY = 2'd2;

  typedef struct packed {
    logic [IdW-1:0]         id;
    logic signed [ValW-1:0] value;
  } entry_t;

  typedef struct packed {
    logic [IdW-1:0]         popped_id;
    logic signed [ValW-1:0] popped_value;
    logic [StatW-1:0]       status;
    logic [HeldW-1:0]       entries_held;
  } res_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_UP_CHK,
    ST_UP_CMP,
    ST_POP_TOP,
    ST_POP_LAST,
    ST_DN_CHK,
    ST_DN_RDL,
    ST_DN_RDR,
    ST_DN_CMP,
    ST_RESULT
  } state_t;

endpackage

// ===== sv/hpq_if.sv =====
// Valid/ready channel interfaces for commands and results.
interface hpq_in_if;
  import hpq_pkg::*;
  logic                   valid;
  logic                   ready;
  logic                   command;
  logic [IdW-1:0]         entry_id;
  logic signed [ValW-1:0] entry_value;
  modport source (output valid, command, entry_id, entry_value, input ready);
  modport sink (input valid, command, entry_id, entry_value, output ready);
endinterface

interface hpq_out_if;
  import hpq_pkg::*;
  logic                   valid;
  logic                   ready;
  logic [IdW-1:0]         popped_id;
  logic signed [ValW-1:0] popped_value;
  logic [StatW-1:0]       status;
  logic [HeldW-1:0]       entries_held;
  modport source (output valid, popped_id, popped_value, status, entries_held,
                  input ready);
  modport sink (input valid, popped_id, popped_value, status, entries_held,
                output ready);
endinterface

// ===== sv/hpq_mem.sv =====
// Heap entry store: one write port, one registered read port.
module hpq_mem #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  logic            clk,
  input  logic            we,
  input  logic [AW-1:0]   waddr,
  input  hpq_pkg::entry_t wdata,
  input  logic [AW-1:0]   raddr,
  output hpq_pkg::entry_t rdata
);
  import hpq_pkg::*;

  entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== sv/hpq_seq.sv =====
// Sift sequencer: walks the heap one level at a time with a shared comparator.
module hpq_seq #(
  parameter int CAPACITY = 1024,
  parameter int CW       = 11,
  parameter int AW       = 10
) (
  input  logic            clk,
  input  logic            rst_n,
  hpq_in_if.sink          in_chan,
  output logic            res_valid,
  input  logic            res_ready,
  output hpq_pkg::res_t   res,
  output logic            mem_we,
  output logic [AW-1:0]   mem_waddr,
  output hpq_pkg::entry_t mem_wdata,
  output logic [AW-1:0]   mem_raddr,
  input  hpq_pkg::entry_t mem_rdata
);
  import hpq_pkg::*;

  state_t           state_r, state_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic [CW-1:0]    pos_r, pos_nxt;
  logic [CW-1:0]    cpos_r, cpos_nxt;
  entry_t           move_r, move_nxt;
  entry_t           child_r, child_nxt;
  entry_t           top_r, top_nxt;
  logic [StatW-1:0] status_r, status_nxt;

  logic signed [ValW-1:0] cmp_a, cmp_b;
  logic                   gt;
  logic [CW:0]            dbl;
  logic [CW:0]            count_ext;

  assign dbl       = {pos_r, 1'b0};
  assign count_ext = {1'b0, count_r};

  // shared comparator
  always_comb begin
    cmp_a = move_r.value;
    cmp_b = mem_rdata.value;
    case (state_r)
      ST_DN_RDR: begin
        cmp_a = mem_rdata.value;
        cmp_b = child_r.value;
      end
      ST_DN_CMP: begin
        cmp_a = child_r.value;
        cmp_b = move_r.value;
      end
      default: begin
        cmp_a = move_r.value;
        cmp_b = mem_rdata.value;
      end
    endcase
    gt = cmp_a > cmp_b;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pos_r    <= pos_nxt;
    cpos_r   <= cpos_nxt;
    move_r   <= move_nxt;
    child_r  <= child_nxt;
    top_r    <= top_nxt;
    status_r <= status_nxt;
  end

  always_comb begin
    state_nxt  = state_r;
    count_nxt  = count_r;
    pos_nxt    = pos_r;
    cpos_nxt   = cpos_r;
    move_nxt   = move_r;
    child_nxt  = child_r;
    top_nxt    = top_r;
    status_nxt = status_r;
    mem_we     = 1'b0;
    mem_waddr  = AW'(pos_r - CW'(1));
    mem_wdata  = move_r;
    mem_raddr  = '0;
    in_chan.ready = (state_r == ST_IDLE);
    res_valid  = 1'b0;

    case (state_r)
      ST_IDLE: begin
        if (in_chan.valid) begin
          move_nxt   = '{id: in_chan.entry_id, value: in_chan.entry_value};
          top_nxt    = '0;
          status_nxt = STAT_OK;
          if (in_chan.command == CMD_INSERT) begin
            if (count_r >= CW'(CAPACITY)) begin
              status_nxt = STAT_FULL;
              state_nxt  = ST_RESULT;
            end else begin
              pos_nxt   = count_r + CW'(1);
              count_nxt = count_r + CW'(1);
              state_nxt = ST_UP_CHK;
            end
          end else if (count_r == '0) begin
            status_nxt = STAT_EMPTY;
            state_nxt  = ST_RESULT;
          end else begin
            mem_raddr = '0;
            state_nxt = ST_POP_TOP;
          end
        end
      end
      ST_UP_CHK: begin
        if (pos_r == CW'(1)) begin
          mem_we    = 1'b1;
          state_nxt = ST_RESULT;
        end else begin
          mem_raddr = AW'((pos_r >> 1) - CW'(1));
          state_nxt = ST_UP_CMP;
        end
      end
      ST_UP_CMP: begin
        mem_we = 1'b1;
        if (gt) begin
          mem_wdata = mem_rdata;
          pos_nxt   = pos_r >> 1;
          state_nxt = ST_UP_CHK;
        end else begin
          state_nxt = ST_RESULT;
        end
      end
      ST_POP_TOP: begin
        top_nxt   = mem_rdata;
        mem_raddr = AW'(count_r - CW'(1));
        state_nxt = ST_POP_LAST;
      end
      ST_POP_LAST: begin
        move_nxt  = mem_rdata;
        count_nxt = count_r - CW'(1);
        pos_nxt   = CW'(1);
        state_nxt = ST_DN_CHK;
      end
      ST_DN_CHK: begin
        if (dbl > count_ext) begin
          mem_we    = 1'b1;
          state_nxt = ST_RESULT;
        end else begin
          mem_raddr = AW'(dbl - (CW+1)'(1));
          state_nxt = ST_DN_RDL;
        end
      end
      ST_DN_RDL: begin
        child_nxt = mem_rdata;
        cpos_nxt  = CW'(dbl);
        if (dbl < count_ext) begin
          mem_raddr = AW'(dbl);
          state_nxt = ST_DN_RDR;
        end else begin
          state_nxt = ST_DN_CMP;
        end
      end
      ST_DN_RDR: begin
        if (gt) begin
          child_nxt = mem_rdata;
          cpos_nxt  = cpos_r + CW'(1);
        end
        state_nxt = ST_DN_CMP;
      end
      ST_DN_CMP: begin
        mem_we = 1'b1;
        if (gt) begin
          mem_wdata = child_r;
          pos_nxt   = cpos_r;
          state_nxt = ST_DN_CHK;
        end else begin
          state_nxt = ST_RESULT;
        end
      end
      ST_RESULT: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign res = '{popped_id:    top_r.id,
                 popped_value: top_r.value,
                 status:       status_r,
                 entries_held: HeldW'(count_r)};

endmodule

// ===== sv/binary_heap_priority_queue.sv =====
// Binary max-heap priority queue: heap store, sift sequencer, result register.
// An insert climbs from the new leaf toward the root and a pop descends from the root,
// one level per compare; an insert when full or a pop when empty skips the walk.
// One transaction is in the sequencer at a time; the next is accepted while a result
// waits in the output register. Reset (rst_n, synchronous): count cleared.
module binary_heap_priority_queue #(
  parameter int CAPACITY = 1024
) (
  input logic      clk,
  input logic      rst_n,
  hpq_in_if.sink   in_chan,
  hpq_out_if.source out_chan
);
  import hpq_pkg::*;

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int AW = $clog2(CAPACITY);

  logic          res_valid;
  logic          res_ready;
  res_t          res;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [AW-1:0] mem_raddr;
  entry_t        mem_wdata;
  entry_t        mem_rdata;

  logic out_valid_r;
  res_t out_data_r;

  hpq_seq #(
    .CAPACITY(CAPACITY),
    .CW(CW),
    .AW(AW)
  ) u_seq (
    .clk(clk),
    .rst_n(rst_n),
    .in_chan(in_chan),
    .res_valid(res_valid),
    .res_ready(res_ready),
    .res(res),
    .mem_we(mem_we),
    .mem_waddr(mem_waddr),
    .mem_wdata(mem_wdata),
    .mem_raddr(mem_raddr),
    .mem_rdata(mem_rdata)
  );

  hpq_mem #(
    .DEPTH(CAPACITY),
    .AW(AW)
  ) u_mem (
    .clk(clk),
    .we(mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .raddr(mem_raddr),
    .rdata(mem_rdata)
  );

  assign res_ready = !out_valid_r || out_chan.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_data_r <= res;
    end
  end

  assign out_chan.valid        = out_valid_r;
  assign out_chan.popped_id    = out_data_r.popped_id;
  assign out_chan.popped_value = out_data_r.popped_value;
  assign out_chan.status       = out_data_r.status;
  assign out_chan.entries_held = out_data_r.entries_held;

`ifndef ASSERT_OFF
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_chan.valid && in_chan.ready |=> !in_chan.ready)
    else $error("transaction accepted while busy");

  a_result_lands: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid && res_ready |=> out_valid_r)
    else $error("result lost before output register");

  a_flag_zero: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid && res.status != STAT_OK |-> res.popped_id == '0 && res.popped_value == '0)
    else $error("flagged result carries data");

  a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid && res.status == STAT_EMPTY |-> res.entries_held == '0)
    else $error("pop on empty with nonzero count");

  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid && res.status == STAT_FULL |-> res.entries_held == HeldW'(CAPACITY))
    else $error("full flag with count below capacity");
`endif

endmodule
